// ===== src/cpfs_pkg.sv =====
// Shared types and constants for the control paragraph field scanner.
package cpfs_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int SPAN_W        = 32;
    localparam int EV_W          = 3;

    localparam logic [EV_W-1:0] EV_NAME    = 3'd0;
    localparam logic [EV_W-1:0] EV_VALUE   = 3'd1;
    localparam logic [EV_W-1:0] EV_PARA    = 3'd2;
    localparam logic [EV_W-1:0] EV_END     = 3'd3;
    localparam logic [EV_W-1:0] EV_ERR_EOF = 3'd4;
    localparam logic [EV_W-1:0] EV_ERR_EOL = 3'd5;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic              last;
    } t_res;

endpackage

// ===== src/cpfs_core.sv =====
// Scanner state and per-transaction decode into up to three ordered results.
module cpfs_core
    import cpfs_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  t_in            i_item,
    output t_res [2:0]     o_res,
    output logic [1:0]     o_cnt
);

    localparam logic [2:0] ST_START   = 3'd0;
    localparam logic [2:0] ST_NAME    = 3'd1;
    localparam logic [2:0] ST_BODY    = 3'd2;
    localparam logic [2:0] ST_NEWLINE = 3'd3;
    localparam logic [2:0] ST_SKIP    = 3'd4;
    localparam logic [2:0] ST_DISCARD = 3'd5;

    logic [2:0]           r_state,      n_state;
    logic [POS_WIDTH-1:0] r_pos,        n_pos;
    logic [POS_WIDTH-1:0] r_para_start, n_para_start;
    logic [POS_WIDTH-1:0] r_name_start, n_name_start;
    logic [POS_WIDTH-1:0] r_val_start,  n_val_start;
    logic [POS_WIDTH-1:0] r_val_end,    n_val_end;
    logic                 r_trim,       n_trim;
    logic                 r_vpend,      n_vpend;

    logic                 f_val, f_b, f_end;
    logic [EV_W-1:0]      b_ev;
    logic [POS_WIDTH-1:0] b_start, b_end;

    always_comb begin
        logic [7:0]           c;
        logic [POS_WIDTH-1:0] pos1;
        logic                 do_name;
        logic [POS_WIDTH-1:0] ns_eff;

        c       = i_item.data_byte;
        pos1    = r_pos + POS_WIDTH'(1);
        do_name = 1'b0;
        ns_eff  = r_name_start;

        n_state      = r_state;
        n_pos        = r_pos;
        n_para_start = r_para_start;
        n_name_start = r_name_start;
        n_val_start  = r_val_start;
        n_val_end    = r_val_end;
        n_trim       = r_trim;
        n_vpend      = r_vpend;
        f_val        = 1'b0;
        f_b          = 1'b0;
        f_end        = 1'b0;
        b_ev         = EV_NAME;
        b_start      = r_name_start;
        b_end        = r_pos;

        if (i_fire) begin
            if (i_item.kind == KIND_EOF) begin
                case (r_state)
                    ST_NAME, ST_BODY: begin
                        f_b     = 1'b1;
                        b_ev    = EV_ERR_EOF;
                        b_start = r_name_start;
                    end
                    ST_NEWLINE, ST_SKIP: begin
                        f_val   = r_vpend;
                        f_b     = 1'b1;
                        b_ev    = EV_PARA;
                        b_start = r_para_start;
                    end
                    default: begin
                    end
                endcase
                f_end        = 1'b1;
                n_state      = ST_START;
                n_pos        = '0;
                n_para_start = '0;
                n_name_start = '0;
                n_val_start  = '0;
                n_val_end    = '0;
                n_trim       = 1'b0;
                n_vpend      = 1'b0;
            end else begin
                n_pos = pos1;
                case (r_state)
                    ST_START: begin
                        if (c == CH_NL) begin
                            n_para_start = pos1;
                        end else begin
                            n_name_start = r_pos;
                            n_state      = ST_NAME;
                            ns_eff       = r_pos;
                            do_name      = 1'b1;
                        end
                    end
                    ST_NAME: begin
                        do_name = 1'b1;
                    end
                    ST_BODY: begin
                        if (c == CH_NL) begin
                            n_val_end = r_pos;
                            n_vpend   = 1'b1;
                            n_trim    = 1'b0;
                            n_state   = ST_NEWLINE;
                        end else if (r_trim && c == CH_SP) begin
                            n_val_start = pos1;
                        end else begin
                            n_trim = 1'b0;
                        end
                    end
                    ST_NEWLINE, ST_SKIP: begin
                        if (c == CH_NL) begin
                            f_val        = r_vpend;
                            n_vpend      = 1'b0;
                            f_b          = 1'b1;
                            b_ev         = EV_PARA;
                            b_start      = r_para_start;
                            n_para_start = pos1;
                            n_state      = ST_START;
                        end else if (c inside {CH_SP, CH_TAB}) begin
                            n_state = ST_SKIP;
                        end else if (r_state == ST_SKIP) begin
                            n_state = ST_BODY;
                        end else begin
                            f_val        = r_vpend;
                            n_vpend      = 1'b0;
                            n_name_start = r_pos;
                            n_state      = ST_NAME;
                            ns_eff       = r_pos;
                            do_name      = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                if (do_name) begin
                    if (c == CH_COLON) begin
                        f_b         = 1'b1;
                        b_ev        = EV_NAME;
                        b_start     = ns_eff;
                        n_val_start = pos1;
                        n_trim      = 1'b1;
                        n_vpend     = 1'b0;
                        n_state     = ST_BODY;
                    end else if (c == CH_NL) begin
                        f_b     = 1'b1;
                        b_ev    = EV_ERR_EOL;
                        b_start = ns_eff;
                        n_state = ST_DISCARD;
                    end
                end
            end
        end
    end

    always_comb begin
        t_res rv, rb, re;

        rv.event_res  = EV_VALUE;
        rv.span_start = SPAN_W'(r_val_start);
        rv.span_end   = SPAN_W'(r_val_end);
        rv.last       = 1'b0;
        rb.event_res  = b_ev;
        rb.span_start = SPAN_W'(b_start);
        rb.span_end   = SPAN_W'(b_end);
        rb.last       = 1'b0;
        re.event_res  = EV_END;
        re.span_start = SPAN_W'(r_pos);
        re.span_end   = SPAN_W'(r_pos);
        re.last       = 1'b0;

        o_res = '0;
        o_cnt = 2'd0;
        case ({f_val, f_b, f_end})
            3'b001: begin o_res[0] = re; o_cnt = 2'd1; end
            3'b010: begin o_res[0] = rb; o_cnt = 2'd1; end
            3'b011: begin o_res[0] = rb; o_res[1] = re; o_cnt = 2'd2; end
            3'b100: begin o_res[0] = rv; o_cnt = 2'd1; end
            3'b101: begin o_res[0] = rv; o_res[1] = re; o_cnt = 2'd2; end
            3'b110: begin o_res[0] = rv; o_res[1] = rb; o_cnt = 2'd2; end
            3'b111: begin
                o_res[0] = rv; o_res[1] = rb; o_res[2] = re; o_cnt = 2'd3;
            end
            default: begin
            end
        endcase

        case (o_cnt)
            2'd1:    o_res[0].last = 1'b1;
            2'd2:    o_res[1].last = 1'b1;
            2'd3:    o_res[2].last = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_START;
            r_pos        <= '0;
            r_para_start <= '0;
            r_name_start <= '0;
            r_val_start  <= '0;
            r_val_end    <= '0;
            r_trim       <= 1'b0;
            r_vpend      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_para_start <= n_para_start;
            r_name_start <= n_name_start;
            r_val_start  <= n_val_start;
            r_val_end    <= n_val_end;
            r_trim       <= n_trim;
            r_vpend      <= n_vpend;
        end
    end

endmodule

// ===== src/control_paragraph_field_scanner.sv =====
// Path: an accepted transaction is held in the input register, then decoded into
// the result slots once they can take it; the slots present its results in order.
// Throughput: one input transaction per cycle while each causes at most one result
// and the output is not stalled; extra results hold the input while they drain.
// Reset (synchronous, active low): scanner returns to start of paragraph,
// position and all spans cleared, input and result stages emptied.
module control_paragraph_field_scanner
    import cpfs_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out
);

    logic       r_in_valid;
    t_in        r_in;
    t_res [2:0] r_slot;
    logic [1:0] r_cnt;

    logic       proc;
    logic       out_take;
    t_res [2:0] core_res;
    logic [1:0] core_cnt;

    assign out_take    = o_out_valid && !i_out_stall;
    assign proc        = r_in_valid && (r_cnt == 2'd0 || (r_cnt == 2'd1 && !i_out_stall));
    assign o_in_stall  = r_in_valid && !proc;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_slot[0];

    cpfs_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc),
        .i_item  (r_in),
        .o_res   (core_res),
        .o_cnt   (core_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (proc) begin
            r_cnt <= core_cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_slot <= core_res;
        end else if (out_take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    a_burst_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && proc |=> r_cnt == $past(core_cnt))
        else $error("result burst count does not match decode");

    a_last_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last == (r_cnt == 2'd1)))
        else $error("last flag not on final result of transaction");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.event_res == EV_END |-> o_out.last)
        else $error("end of input result not last");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_cnt > 2'd1 |-> o_in_stall)
        else $error("input processed while results still queued");

endmodule
